[design/g2e_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the geodetic to ECEF core.
// Ellipsoid constants, fixed-point scale factors and pipeline stage counts.
package g2e_pkg;

    localparam logic [63:0] ONE_Q62    = 64'h4000_0000_0000_0000;
    localparam logic [63:0] PI4_Q62    = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] A_MM       = 64'd6378137000;
    localparam logic [63:0] FLAT_NUM   = 64'd1000000000;
    localparam logic [63:0] INVF_WGS84 = 64'd298257223563;
    localparam logic [63:0] INVF_CGCS  = 64'd298257222101;

    localparam logic [127:0] F_WGS84_W = (128'(FLAT_NUM) << 62) / 128'(INVF_WGS84);
    localparam logic [127:0] F_CGCS_W  = (128'(FLAT_NUM) << 62) / 128'(INVF_CGCS);
    localparam logic [63:0]  F_WGS84   = F_WGS84_W[63:0];
    localparam logic [63:0]  F_CGCS    = F_CGCS_W[63:0];
    localparam logic [127:0] FF_WGS84  = (128'(F_WGS84) * 128'(F_WGS84)) >> 62;
    localparam logic [127:0] FF_CGCS   = (128'(F_CGCS) * 128'(F_CGCS)) >> 62;
    localparam logic [63:0]  E2_WGS84  = {F_WGS84[62:0], 1'b0} - FF_WGS84[63:0];
    localparam logic [63:0]  E2_CGCS   = {F_CGCS[62:0], 1'b0} - FF_CGCS[63:0];

    localparam logic [0:0] REG_ELLIPSOID = 1'b0;

    localparam int MUL_LAT   = 3;
    localparam int TERM_LAT  = 8;
    localparam int SIN_TERMS = 8;
    localparam int COS_TERMS = 9;
    localparam int G_TERMS   = 10;
    localparam int SC_LAT    = 2 + 2 * MUL_LAT + COS_TERMS * TERM_LAT;

    typedef struct packed {
        logic [63:0] sm;
        logic [63:0] cm;
        logic        sn;
        logic        cn;
    } sincos_t;

endpackage

[design/g2e_mulq.sv]
`timescale 1ns / 1ps
// Pipelined 64x64 unsigned multiply with a fixed right shift of the product.
// Four 32x32 partial products, three register stages; uses g2e_pkg.
module g2e_mulq
    import g2e_pkg::*;
#(
    parameter int SHIFT = 62
) (
    input  logic        aclk,
    input  logic        ce,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [63:0]  lo_reg, hi_reg;
    logic [64:0]  mid_reg;
    logic [63:0]  p_reg;
    logic [127:0] full_next;

    always_comb begin
        full_next = {hi_reg, 64'b0} + (128'(mid_reg) << 32) + 128'(lo_reg);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p00_reg <= 64'(a[31:0]) * 64'(b[31:0]);
            p01_reg <= 64'(a[31:0]) * 64'(b[63:32]);
            p10_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            p11_reg <= 64'(a[63:32]) * 64'(b[63:32]);
            mid_reg <= 65'(p01_reg) + 65'(p10_reg);
            lo_reg  <= p00_reg;
            hi_reg  <= p11_reg;
            p_reg   <= 64'(full_next >> SHIFT);
        end
    end

    assign p = p_reg;

endmodule

[design/g2e_term.sv]
`timescale 1ns / 1ps
// One series step: t_out = 1 -/+ floor(mulq(a, t) * NUM / DEN) in Q62.
// Constant division by an exact reciprocal multiply; uses g2e_mulq, g2e_pkg.
module g2e_term
    import g2e_pkg::*;
#(
    parameter int NUM = 1,
    parameter int DEN = 6,
    parameter int SUB = 1
) (
    input  logic        aclk,
    input  logic        ce,
    input  logic [63:0] a_in,
    input  logic [63:0] t_in,
    output logic [63:0] a_out,
    output logic [63:0] t_out
);

    localparam int           RL   = $clog2(DEN);
    localparam int           RK   = 63 + RL;
    localparam logic [127:0] RPOW = 128'(1) << RK;
    localparam logic [127:0] RW   = RPOW / 128'(DEN) + 128'(1);
    localparam logic [63:0]  RCP  = RW[63:0];

    logic [63:0] w, q;
    logic [63:0] v_reg, t_reg, t_next;
    logic [63:0] a_dly_reg [TERM_LAT];

    g2e_mulq #(.SHIFT(62)) u_prod (
        .aclk(aclk), .ce(ce), .a(a_in), .b(t_in), .p(w)
    );

    g2e_mulq #(.SHIFT(RK)) u_quot (
        .aclk(aclk), .ce(ce), .a(v_reg), .b(RCP), .p(q)
    );

    always_comb begin
        if (SUB != 0) begin
            t_next = ONE_Q62 - q;
        end else begin
            t_next = ONE_Q62 + q;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            v_reg        <= 64'(w * 64'(NUM));
            t_reg        <= t_next;
            a_dly_reg[0] <= a_in;
            for (int i = 1; i < TERM_LAT; i++) begin
                a_dly_reg[i] <= a_dly_reg[i-1];
            end
        end
    end

    assign t_out = t_reg;
    assign a_out = a_dly_reg[TERM_LAT-1];

endmodule

[design/g2e_sincos.sv]
`timescale 1ns / 1ps
// Sine and cosine magnitudes and signs of a 48-bit phase, octant folded.
// Horner series through chained g2e_term steps; uses g2e_mulq, g2e_pkg.
module g2e_sincos
    import g2e_pkg::*;
(
    input  logic        aclk,
    input  logic        ce,
    input  logic [47:0] phase,
    output sincos_t     sc
);

    localparam int XD_LEN  = SIN_TERMS * TERM_LAT + MUL_LAT;
    localparam int S0_LEN  = (COS_TERMS - SIN_TERMS) * TERM_LAT - MUL_LAT;
    localparam int OCT_LEN = 2 * MUL_LAT + COS_TERMS * TERM_LAT;

    logic [2:0]  oct_reg;
    logic [45:0] r_reg, r_next;
    logic [63:0] x, x2, s0;
    logic [63:0] sa [SIN_TERMS+1];
    logic [63:0] st [SIN_TERMS+1];
    logic [63:0] ca [COS_TERMS+1];
    logic [63:0] ct [COS_TERMS+1];
    logic [63:0] xd_reg  [XD_LEN];
    logic [63:0] s0d_reg [S0_LEN];
    logic [2:0]  octd_reg [OCT_LEN];
    logic [2:0]  oct_fin;
    sincos_t     sc_reg;

    always_comb begin
        if (phase[45]) begin
            r_next = (46'(1) << 45) - {1'b0, phase[44:0]};
        end else begin
            r_next = {1'b0, phase[44:0]};
        end
    end

    g2e_mulq #(.SHIFT(45)) u_x (
        .aclk(aclk), .ce(ce), .a(64'(r_reg)), .b(PI4_Q62), .p(x)
    );

    g2e_mulq #(.SHIFT(62)) u_x2 (
        .aclk(aclk), .ce(ce), .a(x), .b(x), .p(x2)
    );

    assign sa[0] = x2;
    assign st[0] = ONE_Q62;
    assign ca[0] = x2;
    assign ct[0] = ONE_Q62;

    for (genvar i = 0; i < SIN_TERMS; i++) begin : g_sin
        localparam int K = SIN_TERMS - i;
        g2e_term #(.NUM(1), .DEN((2 * K) * (2 * K + 1)), .SUB(1)) u_term (
            .aclk(aclk), .ce(ce), .a_in(sa[i]), .t_in(st[i]),
            .a_out(sa[i+1]), .t_out(st[i+1])
        );
    end

    for (genvar i = 0; i < COS_TERMS; i++) begin : g_cos
        localparam int K = COS_TERMS - i;
        g2e_term #(.NUM(1), .DEN((2 * K - 1) * (2 * K)), .SUB(1)) u_term (
            .aclk(aclk), .ce(ce), .a_in(ca[i]), .t_in(ct[i]),
            .a_out(ca[i+1]), .t_out(ct[i+1])
        );
    end

    g2e_mulq #(.SHIFT(62)) u_s0 (
        .aclk(aclk), .ce(ce), .a(xd_reg[XD_LEN-1]), .b(st[SIN_TERMS]), .p(s0)
    );

    assign oct_fin = octd_reg[OCT_LEN-1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            oct_reg     <= phase[47:45];
            r_reg       <= r_next;
            xd_reg[0]   <= x;
            s0d_reg[0]  <= s0;
            octd_reg[0] <= oct_reg;
            for (int i = 1; i < XD_LEN; i++) begin
                xd_reg[i] <= xd_reg[i-1];
            end
            for (int i = 1; i < S0_LEN; i++) begin
                s0d_reg[i] <= s0d_reg[i-1];
            end
            for (int i = 1; i < OCT_LEN; i++) begin
                octd_reg[i] <= octd_reg[i-1];
            end
            if (oct_fin[0] ^ oct_fin[1]) begin
                sc_reg.sm <= ct[COS_TERMS];
                sc_reg.cm <= s0d_reg[S0_LEN-1];
            end else begin
                sc_reg.sm <= s0d_reg[S0_LEN-1];
                sc_reg.cm <= ct[COS_TERMS];
            end
            sc_reg.sn <= oct_fin[2];
            sc_reg.cn <= oct_fin[2] ^ oct_fin[1];
        end
    end

    assign sc = sc_reg;

endmodule

[design/geodetic_to_ecef_core.sv]
`timescale 1ns / 1ps
// Geodetic to ECEF top level: stream in, APB register, stream out; uses g2e_sincos, g2e_mulq,
// g2e_term and g2e_pkg.
// Throughput: one request per cycle; every stage is one register of the main pipeline and
// a two-entry output skid keeps input ready high until both skid entries fill.
// Reset: synchronous, active low; clears valid bits, skid state and ellipsoid_select (WGS84).
module geodetic_to_ecef_core
    import g2e_pkg::*;
#(
    parameter int ANGLE_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // latitude, longitude, height_mm
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // ecef_x, ecef_y, ecef_z, zero pad
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int T_U   = SC_LAT + 2 * MUL_LAT;
    localparam int T_G   = T_U + G_TERMS * TERM_LAT;
    localparam int T_N   = T_G + MUL_LAT;
    localparam int T_NE  = T_N + MUL_LAT;
    localparam int T_NZ  = T_NE + 1;
    localparam int T_RHO = T_NZ + MUL_LAT;
    localparam int T_XY  = T_RHO + MUL_LAT;
    localparam int T_FIN = T_XY + 1;

    localparam int LAT_LEN = T_NZ - SC_LAT;
    localparam int LON_LEN = T_RHO - SC_LAT;
    localparam int SGN_LEN = T_XY - SC_LAT;

    logic ell_reg;
    logic ce;
    logic [T_FIN:0] vld_reg;

    logic [47:0]  latph_reg, lonph_reg;
    logic [31:0]  h_reg;
    logic [47:0]  latph_next, lonph_next;
    sincos_t      lat_sc, lon_sc;
    logic [63:0]  e2, u1, u, n, ne, rho, zm, xm, ym;
    logic [63:0]  ga [G_TERMS+1];
    logic [63:0]  gt [G_TERMS+1];
    logic [63:0]  nh_reg, nz_reg, hq, nd;

    logic [31:0]  hd_reg   [T_NE];
    logic [63:0]  nd_reg   [MUL_LAT];
    logic [127:0] latd_reg [LAT_LEN];
    logic [127:0] lond_reg [LON_LEN];
    logic [3:0]   sgnd_reg [SGN_LEN];
    logic [63:0]  zd_reg   [MUL_LAT];
    logic [3:0]   sgn;
    logic [107:0] fin_reg;

    logic         a_valid_reg, b_valid_reg;
    logic [107:0] a_data_reg, b_data_reg;
    logic         pop, push;

    function automatic logic [35:0] round_mm(input logic [63:0] mag, input logic neg);
        logic [63:0] sum;
        logic [35:0] mm;
        sum = mag + (64'(1) << 23);
        mm  = sum[59:24];
        return neg ? 36'(-mm) : mm;
    endfunction

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ELLIPSOID) ? {31'b0, ell_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ell_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ELLIPSOID) begin
            ell_reg <= pwdata[0];
        end
    end

    assign e2 = ell_reg ? E2_CGCS : E2_WGS84;

    // pipeline control
    assign ce       = !b_valid_reg;
    assign s_tready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[T_FIN-1:0], s_tvalid};
        end
    end

    assign latph_next = 48'({{16{s_tdata[31]}}, s_tdata[31:0]} << (48 - ANGLE_BITS));
    assign lonph_next = 48'({{16{s_tdata[63]}}, s_tdata[63:32]} << (48 - ANGLE_BITS));

    g2e_sincos u_lat (.aclk(aclk), .ce(ce), .phase(latph_reg), .sc(lat_sc));
    g2e_sincos u_lon (.aclk(aclk), .ce(ce), .phase(lonph_reg), .sc(lon_sc));

    g2e_mulq #(.SHIFT(62)) u_u1 (
        .aclk(aclk), .ce(ce), .a(lat_sc.sm), .b(lat_sc.sm), .p(u1)
    );
    g2e_mulq #(.SHIFT(62)) u_u (
        .aclk(aclk), .ce(ce), .a(e2), .b(u1), .p(u)
    );

    assign ga[0] = u;
    assign gt[0] = ONE_Q62;

    for (genvar i = 0; i < G_TERMS; i++) begin : g_rad
        localparam int K = G_TERMS - i;
        g2e_term #(.NUM(2 * K - 1), .DEN(2 * K), .SUB(0)) u_term (
            .aclk(aclk), .ce(ce), .a_in(ga[i]), .t_in(gt[i]),
            .a_out(ga[i+1]), .t_out(gt[i+1])
        );
    end

    g2e_mulq #(.SHIFT(38)) u_n (
        .aclk(aclk), .ce(ce), .a(A_MM), .b(gt[G_TERMS]), .p(n)
    );
    g2e_mulq #(.SHIFT(62)) u_ne (
        .aclk(aclk), .ce(ce), .a(n), .b(e2), .p(ne)
    );

    assign hq = {{8{hd_reg[T_NE-1][31]}}, hd_reg[T_NE-1], 24'b0};
    assign nd = nd_reg[MUL_LAT-1];

    g2e_mulq #(.SHIFT(62)) u_rho (
        .aclk(aclk), .ce(ce), .a(nh_reg), .b(latd_reg[LAT_LEN-1][63:0]), .p(rho)
    );
    g2e_mulq #(.SHIFT(62)) u_zm (
        .aclk(aclk), .ce(ce), .a(nz_reg), .b(latd_reg[LAT_LEN-1][127:64]), .p(zm)
    );
    g2e_mulq #(.SHIFT(62)) u_xm (
        .aclk(aclk), .ce(ce), .a(rho), .b(lond_reg[LON_LEN-1][63:0]), .p(xm)
    );
    g2e_mulq #(.SHIFT(62)) u_ym (
        .aclk(aclk), .ce(ce), .a(rho), .b(lond_reg[LON_LEN-1][127:64]), .p(ym)
    );

    // sign order: sin lat, cos lat, sin lon, cos lon
    assign sgn = sgnd_reg[SGN_LEN-1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            latph_reg   <= latph_next;
            lonph_reg   <= lonph_next;
            h_reg       <= s_tdata[95:64];
            hd_reg[0]   <= h_reg;
            nd_reg[0]   <= n;
            latd_reg[0] <= {lat_sc.sm, lat_sc.cm};
            lond_reg[0] <= {lon_sc.sm, lon_sc.cm};
            sgnd_reg[0] <= {lat_sc.sn, lat_sc.cn, lon_sc.sn, lon_sc.cn};
            zd_reg[0]   <= zm;
            for (int i = 1; i < T_NE; i++) begin
                hd_reg[i] <= hd_reg[i-1];
            end
            for (int i = 1; i < MUL_LAT; i++) begin
                nd_reg[i] <= nd_reg[i-1];
                zd_reg[i] <= zd_reg[i-1];
            end
            for (int i = 1; i < LAT_LEN; i++) begin
                latd_reg[i] <= latd_reg[i-1];
            end
            for (int i = 1; i < LON_LEN; i++) begin
                lond_reg[i] <= lond_reg[i-1];
            end
            for (int i = 1; i < SGN_LEN; i++) begin
                sgnd_reg[i] <= sgnd_reg[i-1];
            end
            nh_reg  <= nd + hq;
            nz_reg  <= nd - ne + hq;
            fin_reg <= {round_mm(zd_reg[MUL_LAT-1], sgn[3]),
                        round_mm(ym, sgn[2] ^ sgn[1]),
                        round_mm(xm, sgn[2] ^ sgn[0])};
        end
    end

    // output skid
    assign pop      = a_valid_reg && m_tready;
    assign push     = ce && vld_reg[T_FIN];
    assign m_tvalid = a_valid_reg;
    assign m_tdata  = {4'b0, a_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (!a_valid_reg || pop) begin
            if (b_valid_reg) begin
                a_valid_reg <= 1'b1;
                b_valid_reg <= 1'b0;
            end else begin
                a_valid_reg <= push;
            end
        end else if (push) begin
            b_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!a_valid_reg || pop) begin
            a_data_reg <= b_valid_reg ? b_data_reg : fin_reg;
        end else if (push) begin
            b_data_reg <= fin_reg;
        end
    end

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> a_valid_reg)
        else $error("skid second entry holds data while first is empty");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && m_tready |=> !b_valid_reg)
        else $error("skid second entry not drained on output request");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[T_FIN] && !ce |=> vld_reg[T_FIN])
        else $error("last pipeline stage lost its request during stall");

endmodule

[sim/tb_geodetic_to_ecef_core.sv]
`timescale 1ns / 1ps
// Self-checking bench for geodetic_to_ecef_core: directed table, then random positions.
// Each result is checked against a fixed-point predictor of the conversion or a known table value; needs g2e_pkg.
module tb_geodetic_to_ecef_core;
    import g2e_pkg::*;

    localparam int N_RANDOM   = 1450;
    localparam int LATENCY    = 181;
    localparam int LIMIT      = 400000;
    localparam int N_DIRECTED = 20;

    typedef struct packed {
        logic signed [35:0] z;
        logic signed [35:0] y;
        logic signed [35:0] x;
    } ecef_t;

    typedef struct {
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] hgt;
        logic        known;
        ecef_t       res;
    } row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;   // latitude, longitude, height_mm
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;   // ecef_x, ecef_y, ecef_z, zero pad
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    ecef_t  ecef_queue[$];
    logic   ellipsoid;
    int     mismatches;
    int     cycles;
    logic   recv_hold;
    logic   recv_idle_on;
    logic   send_idle_on;
    logic   hold_req;
    row_t   directed[N_DIRECTED];

    geodetic_to_ecef_core u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return 64'(p >> s);
    endfunction

    function automatic void trig(input logic [47:0] ph, output logic [63:0] sm,
                                 output logic sn, output logic [63:0] cm, output logic cn);
        logic [2:0]  oct;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s0;
        oct = ph[47:45];
        r = 64'(ph[44:0]);
        if (oct[0]) r = (64'd1 << 45) - r;
        x = qmul(r, PI4_Q62, 45);
        x2 = qmul(x, x, 62);
        t = ONE_Q62;
        for (int k = 8; k >= 1; k--) t = ONE_Q62 - qmul(x2, t, 62) / 64'((2*k) * (2*k + 1));
        s0 = qmul(x, t, 62);
        t = ONE_Q62;
        for (int k = 9; k >= 1; k--) t = ONE_Q62 - qmul(x2, t, 62) / 64'((2*k - 1) * (2*k));
        if (((oct + 3'd1) & 3'd2) != 0) begin
            sm = t;
            cm = s0;
        end else begin
            sm = s0;
            cm = t;
        end
        sn = oct[2];
        cn = (((oct + 3'd2) & 3'd4) != 0);
    endfunction

    function automatic logic [35:0] to_mm(logic [63:0] mag, logic neg);
        logic [63:0] mm;
        mm = (mag + (64'd1 << 23)) >> 24;
        if (neg) mm = 64'd0 - mm;
        return mm[35:0];
    endfunction

    function automatic ecef_t convert(logic [31:0] lat, logic [31:0] lon, logic [31:0] hgt,
                                      logic sel);
        logic [63:0] invf;
        logic [63:0] f;
        logic [63:0] rem;
        logic [63:0] e2;
        logic [63:0] u;
        logic [63:0] g;
        logic [63:0] n;
        logic [63:0] h;
        logic [63:0] nh;
        logic [63:0] nz;
        logic [63:0] rho;
        logic [63:0] slm;
        logic [63:0] clm;
        logic [63:0] sgm;
        logic [63:0] cgm;
        logic        sln;
        logic        cln;
        logic        sgn;
        logic        cgn;
        ecef_t       e;
        invf = sel ? INVF_CGCS : INVF_WGS84;
        f = 0;
        rem = FLAT_NUM;
        for (int i = 0; i < 62; i++) begin
            rem = rem << 1;
            f = f << 1;
            if (rem >= invf) begin
                rem = rem - invf;
                f[0] = 1'b1;
            end
        end
        e2 = 2 * f - qmul(f, f, 62);
        trig({lat, 16'd0}, slm, sln, clm, cln);
        trig({lon, 16'd0}, sgm, sgn, cgm, cgn);
        u = qmul(e2, qmul(slm, slm, 62), 62);
        g = ONE_Q62;
        for (int k = 10; k >= 1; k--) g = ONE_Q62 + qmul(u, g, 62) * 64'(2*k - 1) / 64'(2*k);
        n = qmul(A_MM, g, 38);
        h = {{32{hgt[31]}}, hgt} << 24;
        nh = n + h;
        nz = n - qmul(n, e2, 62) + h;
        rho = qmul(nh, clm, 62);
        e.x = to_mm(qmul(rho, cgm, 62), cln != cgn);
        e.y = to_mm(qmul(rho, sgm, 62), cln != sgn);
        e.z = to_mm(qmul(nz, slm, 62), sln);
        return e;
    endfunction

    task automatic write_ellipsoid(logic sel);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(REG_ELLIPSOID) << 2;
        pwdata <= {$urandom_range(0, 1) ? 31'h7fffffff : 31'd0, sel};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        ellipsoid = sel;
    endtask

    task automatic send_position(logic [31:0] lat, logic [31:0] lon, logic [31:0] hgt,
                                 logic known, ecef_t res);
        ecef_t e;
        while (send_idle_on && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {hgt, lon, lat};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        e = known ? res : convert(lat, lon, hgt, ellipsoid);
        ecef_queue.push_back(e);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (ecef_queue.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_lat();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h4000_0000 : 32'hc000_0000;
            default: return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_hgt();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 20000000)) - 32'sd1000000);
        endcase
    endfunction

    // check results
    always @(posedge aclk) begin
        ecef_t got;
        ecef_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[107:0];
            if (ecef_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = ecef_queue.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z
                    || m_tdata[111:108] !== 4'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                 want.x, want.y, want.z, got.x, got.y, got.z);
                end
            end
        end
    end

    // receiver: random stall, plus one long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req && !recv_hold) begin
            recv_hold <= 1'b1;
            m_tready <= 1'b0;
            for (int i = 0; i < 600; i++) @(negedge aclk);
            recv_hold <= 1'b0;
        end else begin
            m_tready <= !(recv_idle_on && $urandom_range(0, 99) < 34);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        directed[0]  = '{32'h0, 32'h0, 32'h0, 1'b1, '{36'sd0, 36'sd0, 36'sd6378137000}};
        directed[1]  = '{32'h4000_0000, 32'h0, 32'h0, 1'b0, '0};
        directed[2]  = '{32'hc000_0000, 32'h0, 32'h0, 1'b0, '0};
        directed[3]  = '{32'h0, 32'h4000_0000, 32'h0, 1'b1, '{36'sd0, 36'sd6378137000, 36'sd0}};
        directed[4]  = '{32'h0, 32'h8000_0000, 32'h0, 1'b1, '{36'sd0, 36'sd0, -36'sd6378137000}};
        directed[5]  = '{32'h0, 32'hc000_0000, 32'h0, 1'b0, '0};
        directed[6]  = '{32'h0, 32'h7fff_ffff, 32'h0, 1'b0, '0};
        directed[7]  = '{32'h0, 32'h0, 32'h7fff_ffff, 1'b0, '0};
        directed[8]  = '{32'h0, 32'h0, 32'h8000_0000, 1'b0, '0};
        directed[9]  = '{32'h4000_0000, 32'h2000_0000, 32'h7fff_ffff, 1'b0, '0};
        directed[10] = '{32'hc000_0000, 32'he000_0000, 32'h8000_0000, 1'b0, '0};
        directed[11] = '{32'h4000_0001, 32'h0, 32'h0, 1'b0, '0};
        directed[12] = '{32'h7fff_ffff, 32'h1234_5678, 32'd1000, 1'b0, '0};
        directed[13] = '{32'h8000_0000, 32'h0, 32'h0, 1'b0, '0};
        directed[14] = '{32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 1'b0, '0};
        directed[15] = '{32'h2000_0000, 32'h6000_0000, 32'd8848000, 1'b0, '0};
        directed[16] = '{32'hbfff_ffff, 32'ha000_0000, 32'h0, 1'b0, '0};
        directed[17] = '{32'h1000_0000, 32'h1000_0000, 32'h1, 1'b0, '0};
        directed[18] = '{32'h3fff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, '0};
        directed[19] = '{32'hc000_0001, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, '0};

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        m_tready = 1'b0;
        ellipsoid = 1'b0;
        mismatches = 0;
        cycles = 0;
        recv_hold = 1'b0;
        hold_req = 1'b0;
        recv_idle_on = 1'b1;
        send_idle_on = 1'b1;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_position(directed[i].lat, directed[i].lon, directed[i].hgt,
                          directed[i].known, directed[i].res);
        drain();
        write_ellipsoid(1'b1);
        for (int i = 0; i < N_DIRECTED; i++)
            send_position(directed[i].lat, directed[i].lon, directed[i].hgt, 1'b0, '0);
        drain();

        // random phases: toggle ellipsoid, one back-to-back stretch, one long hold-off
        for (int ph = 0; ph < 6; ph++) begin
            write_ellipsoid(ph[0]);
            recv_idle_on = (ph != 2);
            send_idle_on = (ph != 2);
            if (ph == 3) hold_req = 1'b1;
            for (int i = 0; i < N_RANDOM / 6; i++) begin
                if (i == 20) hold_req = 1'b0;
                send_position(rand_lat(), $urandom, rand_hgt(), 1'b0, '0);
            end
            drain();
        end

        if (mismatches == 0 && ecef_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[geodetic_to_ecef_core.f]
design/g2e_pkg.sv
design/g2e_mulq.sv
design/g2e_term.sv
design/g2e_sincos.sv
design/geodetic_to_ecef_core.sv
sim/tb_geodetic_to_ecef_core.sv
